// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the decompressor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LZSSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define LZSSD_ASSERT_IMP(lbl, ante, cons, msg) \
  `LZSSD_ASSERT(lbl, (ante) |-> (cons), msg)

`define LZSSD_ASSERT_NXT(lbl, ante, cons, msg) \
  `LZSSD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/core/lzssd_pkg.sv
package lzssd_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 4096;
  localparam int unsigned DATA_W          = 8;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned DIST_W          = 12;
  localparam int unsigned CNT_W           = 5;
  localparam int unsigned BIDX_W          = 4;

  localparam logic [DATA_W-1:0] SPACE_BYTE    = 8'h20;
  localparam logic [CNT_W-1:0]  LEN_BIAS      = 5'd3;
  localparam logic [CNT_W-1:0]  MAX_COPY_LEN  = 5'd18;
  localparam logic [BIDX_W-1:0] BITS_PER_FLAG = 4'd8;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TRUNC    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

endpackage

// File: rtl/core/lzssd_if.sv
interface lzssd_in_if;
  import lzssd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzssd_out_if;
  import lzssd_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   out_byte;
  logic                is_report;
  logic [STATUS_W-1:0] status;
  logic                last_result;

  modport source (output valid, output out_byte, output is_report, output status,
                  output last_result, input ready);
  modport sink (input valid, input out_byte, input is_report, input status,
                input last_result, output ready);
endinterface

// File: rtl/core/lzssd_hist_ram.sv
module lzssd_hist_ram #(
  parameter int unsigned WINDOW_SIZE = lzssd_pkg::WINDOW_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(WINDOW_SIZE)-1:0] waddr,
  input  logic [lzssd_pkg::DATA_W-1:0]   wdata,
  input  logic                           re,
  input  logic [$clog2(WINDOW_SIZE)-1:0] raddr,
  output logic [lzssd_pkg::DATA_W-1:0]   rdata
);
  import lzssd_pkg::*;

  logic [DATA_W-1:0] mem [WINDOW_SIZE];

  // A read of the entry being written in the same cycle returns the new byte.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

// File: rtl/core/lzss_decompressor_with_sum_check_core.sv
// LZSS decompressor with a 4 KiB history window and a closing 32-bit sum check. Compressed
// bytes are taken one item at a time; a literal token gives its byte to the registered output
// as it is taken, a flag byte or the low byte of a pointer is just stored, and the high byte
// of a pointer of length L (3 to 18) starts a copy that reads the history memory one byte per
// cycle through its registered read port unless back-pressure holds it. The item
// marked last is followed by a status report. Back-pressure on the result side stalls the
// copy. The history needs no clearing pass after reset, so items are taken straight away.
module lzss_decompressor_with_sum_check_core #(
  parameter int unsigned WINDOW_SIZE = lzssd_pkg::WINDOW_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lzssd_pkg::WORD_W-1:0] cfg_wdata,
  lzssd_in_if.sink                     in_stream,
  lzssd_out_if.source                  out_stream
);
  import lzssd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(WINDOW_SIZE);

  typedef enum logic [1:0] {S_IN, S_COPY, S_REPORT} state_t;
  typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_HIGH} phase_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [WORD_W-1:0]   out_len_r, out_len_nxt;
  logic [WORD_W-1:0]   produced_r, produced_nxt;
  logic [WORD_W-1:0]   sum_r, sum_nxt;
  logic [WORD_W-1:0]   tail_r, tail_nxt;
  logic [DATA_W-1:0]   flag_r, flag_nxt;
  logic [BIDX_W-1:0]   bit_idx_r, bit_idx_nxt;
  logic [DATA_W-1:0]   ptr_low_r, ptr_low_nxt;
  logic [ADDR_W-1:0]   wa_r, wa_nxt;
  logic [ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]    cp_left_r, cp_left_nxt;
  logic                cp_pend_r, cp_pend_nxt;
  logic                space_r, space_nxt;
  logic                last_pend_r, last_pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_byte_r, out_byte_nxt;
  logic                is_report_r, is_report_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                last_result_r, last_result_nxt;

  logic                out_free;
  logic                in_ready;
  logic                in_acc;
  logic                decoding;
  logic [DATA_W-1:0]   in_b;
  logic [DIST_W-1:0]   back_dist;
  logic [CNT_W-1:0]    len;
  logic                emit;
  logic [DATA_W-1:0]   emit_byte;
  logic                next_tok;
  logic                clear;
  logic                mem_re;
  logic [DATA_W-1:0]   mem_rdata;

  lzssd_hist_ram #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_hist (
    .clk  (clk),
    .we   (emit),
    .waddr(wa_r),
    .wdata(emit_byte),
    .re   (mem_re),
    .raddr(rd_addr_r),
    .rdata(mem_rdata)
  );

  assign out_free  = !out_valid_r || out_stream.ready;
  assign in_ready  = (state_r == S_IN) && out_free;
  assign in_acc    = in_stream.valid && in_ready;
  assign decoding  = produced_r < out_len_r;
  assign in_b      = in_stream.data_byte;
  assign back_dist = {in_b[7:4], ptr_low_r};
  assign len       = {1'b0, in_b[3:0]} + LEN_BIAS;

  assign in_stream.ready        = in_ready;
  assign out_stream.valid       = out_valid_r;
  assign out_stream.out_byte    = out_byte_r;
  assign out_stream.is_report   = is_report_r;
  assign out_stream.status      = status_r;
  assign out_stream.last_result = last_result_r;

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    out_len_nxt     = cfg_we ? cfg_wdata : out_len_r;
    produced_nxt    = produced_r;
    sum_nxt         = sum_r;
    tail_nxt        = tail_r;
    flag_nxt        = flag_r;
    bit_idx_nxt     = bit_idx_r;
    ptr_low_nxt     = ptr_low_r;
    wa_nxt          = wa_r;
    rd_addr_nxt     = rd_addr_r;
    cp_left_nxt     = cp_left_r;
    cp_pend_nxt     = cp_pend_r;
    space_nxt       = space_r;
    last_pend_nxt   = last_pend_r;
    out_valid_nxt   = out_valid_r && !out_stream.ready;
    out_byte_nxt    = out_byte_r;
    is_report_nxt   = is_report_r;
    status_nxt      = status_r;
    last_result_nxt = last_result_r;
    emit            = 1'b0;
    emit_byte       = in_b;
    next_tok        = 1'b0;
    clear           = 1'b0;
    mem_re          = 1'b0;

    unique case (state_r)
      S_IN: begin
        if (in_acc) begin
          tail_nxt      = {in_b, tail_r[WORD_W-1:DATA_W]};
          last_pend_nxt = in_stream.last_byte;
          state_nxt     = in_stream.last_byte ? S_REPORT : S_IN;
          if (decoding) begin
            unique case (phase_r)
              PH_FLAG: begin
                flag_nxt    = in_b;
                bit_idx_nxt = '0;
                phase_nxt   = PH_TOKEN;
              end
              PH_TOKEN: begin
                if (flag_r[0]) begin
                  emit     = 1'b1;
                  next_tok = 1'b1;
                end else begin
                  ptr_low_nxt = in_b;
                  phase_nxt   = PH_HIGH;
                end
              end
              PH_HIGH: begin
                if (back_dist != '0) begin
                  state_nxt   = S_COPY;
                  space_nxt   = {{(WORD_W-DIST_W){1'b0}}, back_dist} > produced_r;
                  rd_addr_nxt = wa_r - ADDR_W'(back_dist);
                  cp_left_nxt = len;
                  cp_pend_nxt = 1'b0;
                end else begin
                  next_tok = 1'b1;
                end
              end
              default: begin
                phase_nxt = PH_FLAG;
              end
            endcase
          end
        end
      end
      S_COPY: begin
        if (!cp_pend_r) begin
          mem_re      = 1'b1;
          rd_addr_nxt = rd_addr_r + 1'b1;
          cp_left_nxt = cp_left_r - 1'b1;
          cp_pend_nxt = 1'b1;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_byte = space_r ? SPACE_BYTE : mem_rdata;
          if (cp_left_r != '0) begin
            mem_re      = 1'b1;
            rd_addr_nxt = rd_addr_r + 1'b1;
            cp_left_nxt = cp_left_r - 1'b1;
          end else begin
            cp_pend_nxt = 1'b0;
            next_tok    = 1'b1;
            state_nxt   = last_pend_r ? S_REPORT : S_IN;
          end
        end
      end
      S_REPORT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = '0;
          is_report_nxt   = 1'b1;
          last_result_nxt = 1'b1;
          if (decoding) begin
            status_nxt = STATUS_TRUNC;
          end else if (sum_r == tail_r) begin
            status_nxt = STATUS_OK;
          end else begin
            status_nxt = STATUS_MISMATCH;
          end
          clear     = 1'b1;
          state_nxt = S_IN;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase

    if (next_tok) begin
      flag_nxt    = flag_r >> 1;
      bit_idx_nxt = bit_idx_r + 1'b1;
      phase_nxt   = (bit_idx_nxt >= BITS_PER_FLAG) ? PH_FLAG : PH_TOKEN;
    end

    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_byte_nxt    = emit_byte;
      is_report_nxt   = 1'b0;
      status_nxt      = STATUS_OK;
      last_result_nxt = 1'b0;
      produced_nxt    = (produced_r == '1) ? produced_r : produced_r + 1'b1;
      sum_nxt         = sum_r + WORD_W'(emit_byte);
      wa_nxt          = wa_r + 1'b1;
    end

    if (clear) begin
      produced_nxt = '0;
      sum_nxt      = '0;
      tail_nxt     = '0;
      flag_nxt     = '0;
      bit_idx_nxt  = '0;
      phase_nxt    = PH_FLAG;
      ptr_low_nxt  = '0;
      wa_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      phase_r     <= PH_FLAG;
      out_len_r   <= '0;
      produced_r  <= '0;
      sum_r       <= '0;
      tail_r      <= '0;
      flag_r      <= '0;
      bit_idx_r   <= '0;
      ptr_low_r   <= '0;
      wa_r        <= '0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_len_r   <= out_len_nxt;
      produced_r  <= produced_nxt;
      sum_r       <= sum_nxt;
      tail_r      <= tail_nxt;
      flag_r      <= flag_nxt;
      bit_idx_r   <= bit_idx_nxt;
      ptr_low_r   <= ptr_low_nxt;
      wa_r        <= wa_nxt;
      cp_pend_r   <= cp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_r     <= rd_addr_nxt;
    cp_left_r     <= cp_left_nxt;
    space_r       <= space_nxt;
    last_pend_r   <= last_pend_nxt;
    out_byte_r    <= out_byte_nxt;
    is_report_r   <= is_report_nxt;
    status_r      <= status_nxt;
    last_result_r <= last_result_nxt;
  end

`include "assert_macros.svh"

  `LZSSD_ASSERT(a_bit_idx_range, bit_idx_r <= BITS_PER_FLAG, "flag bit index out of range")
  `LZSSD_ASSERT_IMP(a_copy_len, state_r == S_COPY, cp_left_r <= MAX_COPY_LEN,
                    "copy count too large")
  `LZSSD_ASSERT_IMP(a_no_take_busy, state_r != S_IN, !in_stream.ready, "item taken while busy")
  `LZSSD_ASSERT_NXT(a_report_clears, (state_r == S_REPORT) && out_free,
                    (produced_r == '0) && (wa_r == '0) && (phase_r == PH_FLAG),
                    "stream state not cleared after report")

endmodule
